### sv/spwf_pkg.sv
`default_nettype none

package spwf_pkg;

  localparam int SAMPLE_BITS      = 24;
  localparam int PAN_BITS         = 16;
  localparam int MAX_BLOCK_LOG2   = 12;
  localparam int BLOCK_LOG2_BITS  = 4;
  localparam int SINE_DEPTH_LOG2  = 8;
  localparam int SINE_TABLE_DEPTH = 1 << SINE_DEPTH_LOG2;

  localparam int GAIN_W = 17;
  localparam int DIFF_W = GAIN_W + 1;
  localparam int STEP_W = DIFF_W + MAX_BLOCK_LOG2;
  localparam int ACC_W  = DIFF_W + 2 * MAX_BLOCK_LOG2 + 1;
  localparam int IDX_W  = MAX_BLOCK_LOG2;
  localparam int PROD_W = SAMPLE_BITS + GAIN_W + 1;

  localparam logic [GAIN_W-1:0] UNITY_GAIN  = GAIN_W'(65536);
  localparam logic [GAIN_W-1:0] CENTRE_GAIN = GAIN_W'(46341);
  localparam logic signed [PAN_BITS-1:0] PAN_MAX = PAN_BITS'(16384);
  localparam logic signed [PAN_BITS-1:0] PAN_MIN = -PAN_BITS'(16384);
  localparam logic [BLOCK_LOG2_BITS-1:0] BLOCK_LOG2_RESET = BLOCK_LOG2_BITS'(8);
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = BLOCK_LOG2_BITS;
  localparam logic [CFG_IDX_W-1:0] REG_PAN_LAW    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LOG2 = CFG_IDX_W'(1);

  typedef logic [SINE_TABLE_DEPTH:0][GAIN_W-1:0] sine_rom_t;

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] x;
    logic [63:0] t;
    longint      sum;
    longint      g;
    rom = '0;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      x = (64'(k) * HALF_PI_Q30 + 64'(SINE_TABLE_DEPTH / 2)) >> SINE_DEPTH_LOG2;
      t = x;
      sum = longint'(x);
      for (int n = 1; n <= 6; n++) begin
        t = (t * x) >> 30;
        t = (t * x) >> 30;
        case (n)
          1: t = t / 64'd6;
          2: t = t / 64'd20;
          3: t = t / 64'd42;
          4: t = t / 64'd72;
          5: t = t / 64'd110;
          default: t = t / 64'd156;
        endcase
        if (n % 2 == 1) begin
          sum = sum - longint'(t);
        end else begin
          sum = sum + longint'(t);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      g = (sum + 8192) >>> 14;
      if (g > 65536) begin
        g = 65536;
      end
      rom[k] = GAIN_W'(g);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

### sv/stereo_pan_law_with_fade.sv
`default_nettype none
// Channel    Handshake                 Payload
// item       item_valid / item_stall   sample_in, pan_amount
// result     result_valid/result_stall left_out, right_out, block_end
// cfg        cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One item per cycle sustained while the result is not stalled.
// Path: input register, gain stage (pan clamp, sine table, ramp accumulator),
// multiply/round/saturate stage into the result register.
// Reset is synchronous: centre pan, gains 46341, equal-power law, block_log2 8.
// A stalled result holds the pipeline; item_stall rises only once all three
// registers are full.

module stereo_pan_law_with_fade
  import spwf_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          item_valid,
  output logic                               item_stall,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
  input  wire logic signed [PAN_BITS-1:0]    pan_amount,
  output logic                               result_valid,
  input  wire logic                          result_stall,
  output logic signed [SAMPLE_BITS-1:0]      left_out,
  output logic signed [SAMPLE_BITS-1:0]      right_out,
  output logic                               block_end,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [CFG_DATA_W-1:0]         cfg_data
);

  localparam logic signed [ACC_W-1:0] ACC_TOP =
    $signed(ACC_W'(UNITY_GAIN)) <<< MAX_BLOCK_LOG2;
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(32768);
  localparam logic signed [PROD_W-17:0] SAT_HI = (PROD_W-16)'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [PROD_W-17:0] SAT_LO = -SAT_HI - (PROD_W-16)'(1);

  function automatic logic [GAIN_W-1:0] quarter_sine(input logic [15:0] f);
    logic [15+SINE_DEPTH_LOG2:0] pos;
    logic [SINE_DEPTH_LOG2:0]    idx;
    logic [SINE_DEPTH_LOG2:0]    idx_hi;
    logic [14:0]                 fr;
    logic [GAIN_W-1:0]           a;
    logic [GAIN_W-1:0]           b;
    logic [GAIN_W-1:0]           d;
    logic [31:0]                 prod;
    logic [GAIN_W-1:0]           interp;
    pos = {f, SINE_DEPTH_LOG2'(0)};
    idx = pos[15+SINE_DEPTH_LOG2:15];
    fr  = pos[14:0];
    idx_hi = {1'b0, idx[SINE_DEPTH_LOG2-1:0]} + (SINE_DEPTH_LOG2+1)'(1);
    a = SINE_ROM[{1'b0, idx[SINE_DEPTH_LOG2-1:0]}];
    b = SINE_ROM[idx_hi];
    d = (b > a) ? b - a : '0;
    prod = 32'(d) * 32'(fr);
    interp = GAIN_W'((prod + 32'd16384) >> 15);
    if (idx[SINE_DEPTH_LOG2]) begin
      return SINE_ROM[SINE_TABLE_DEPTH];
    end
    return a + interp;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] scale_sat(
    input logic signed [SAMPLE_BITS-1:0] s,
    input logic [GAIN_W-1:0]             g
  );
    logic signed [PROD_W-1:0]  p;
    logic signed [PROD_W-17:0] q;
    p = $signed(PROD_W'(s)) * $signed(PROD_W'({1'b0, g}));
    q = (PROD_W-16)'((p + ROUND_HALF) >>> 16);
    if (q > SAT_HI) begin
      q = SAT_HI;
    end else if (q < SAT_LO) begin
      q = SAT_LO;
    end
    return q[SAMPLE_BITS-1:0];
  endfunction

  logic                          pan_law;
  logic [BLOCK_LOG2_BITS-1:0]    block_log2;

  logic                          s1_valid;
  logic signed [SAMPLE_BITS-1:0] s1_sample;
  logic signed [PAN_BITS-1:0]    s1_pan;
  logic                          s2_valid;
  logic signed [SAMPLE_BITS-1:0] s2_sample;
  logic [GAIN_W-1:0]             s2_gain_l;
  logic [GAIN_W-1:0]             s2_gain_r;
  logic                          s2_end;

  logic [IDX_W-1:0]              sample_index;
  logic signed [PAN_BITS-1:0]    held_pan;
  logic [GAIN_W-1:0]             held_left_gain;
  logic [GAIN_W-1:0]             held_right_gain;
  logic signed [ACC_W-1:0]       left_ramp_acc;
  logic signed [ACC_W-1:0]       right_ramp_acc;
  logic signed [STEP_W-1:0]      left_ramp_step;
  logic signed [STEP_W-1:0]      right_ramp_step;

  logic                          item_fire;
  logic                          out_ready;
  logic                          s2_ready;
  logic                          s1_move;
  logic                          s2_move;

  logic [BLOCK_LOG2_BITS-1:0]    blk_len;
  logic [BLOCK_LOG2_BITS-1:0]    shamt;
  logic [IDX_W:0]                blk_size;
  logic                          first;
  logic                          last;
  logic signed [PAN_BITS-1:0]    pan_c;
  logic                          changed;
  logic [15:0]                   fpos;
  logic [15:0]                   fneg;
  logic [GAIN_W-1:0]             new_left;
  logic [GAIN_W-1:0]             new_right;
  logic signed [DIFF_W-1:0]      diff_l;
  logic signed [DIFF_W-1:0]      diff_r;
  logic signed [STEP_W-1:0]      step_l_new;
  logic signed [STEP_W-1:0]      step_r_new;
  logic signed [ACC_W-1:0]       acc_l_used;
  logic signed [ACC_W-1:0]       acc_r_used;
  logic [GAIN_W-1:0]             gain_l;
  logic [GAIN_W-1:0]             gain_r;

  assign cfg_ready  = 1'b1;
  assign item_fire  = item_valid && !item_stall;
  assign out_ready  = !result_valid || !result_stall;
  assign s2_ready   = !s2_valid || out_ready;
  assign s1_move    = s1_valid && s2_ready;
  assign s2_move    = s2_valid && out_ready;
  assign item_stall = s1_valid && !s2_ready;

  always_comb begin
    blk_len = (block_log2 > BLOCK_LOG2_BITS'(MAX_BLOCK_LOG2)) ?
              BLOCK_LOG2_BITS'(MAX_BLOCK_LOG2) : block_log2;
    shamt    = BLOCK_LOG2_BITS'(MAX_BLOCK_LOG2) - blk_len;
    blk_size = (IDX_W+1)'(1) << blk_len;
    first    = (sample_index == '0);
    last     = ({1'b0, sample_index} + (IDX_W+1)'(1)) >= blk_size;

    if (s1_pan > PAN_MAX) begin
      pan_c = PAN_MAX;
    end else if (s1_pan < PAN_MIN) begin
      pan_c = PAN_MIN;
    end else begin
      pan_c = s1_pan;
    end
    changed = first && (pan_c != held_pan);
    fpos = 16'(pan_c + PAN_MAX);
    fneg = 16'(17'd32768 - {1'b0, fpos});

    if (pan_law) begin
      new_left  = {fneg, 1'b0};
      new_right = {fpos, 1'b0};
    end else begin
      new_left  = quarter_sine(fneg);
      new_right = quarter_sine(fpos);
    end

    diff_l = $signed({1'b0, new_left}) - $signed({1'b0, held_left_gain});
    diff_r = $signed({1'b0, new_right}) - $signed({1'b0, held_right_gain});
    step_l_new = changed ? (STEP_W'(diff_l) <<< shamt) : '0;
    step_r_new = changed ? (STEP_W'(diff_r) <<< shamt) : '0;

    if (first) begin
      acc_l_used = $signed(ACC_W'(held_left_gain)) <<< MAX_BLOCK_LOG2;
      acc_r_used = $signed(ACC_W'(held_right_gain)) <<< MAX_BLOCK_LOG2;
    end else begin
      acc_l_used = left_ramp_acc + ACC_W'(left_ramp_step);
      acc_r_used = right_ramp_acc + ACC_W'(right_ramp_step);
    end

    if (acc_l_used[ACC_W-1]) begin
      gain_l = '0;
    end else if (acc_l_used > ACC_TOP) begin
      gain_l = UNITY_GAIN;
    end else begin
      gain_l = acc_l_used[MAX_BLOCK_LOG2 +: GAIN_W];
    end
    if (acc_r_used[ACC_W-1]) begin
      gain_r = '0;
    end else if (acc_r_used > ACC_TOP) begin
      gain_r = UNITY_GAIN;
    end else begin
      gain_r = acc_r_used[MAX_BLOCK_LOG2 +: GAIN_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pan_law    <= 1'b0;
      block_log2 <= BLOCK_LOG2_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PAN_LAW:    pan_law    <= cfg_data[0];
        REG_BLOCK_LOG2: block_log2 <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (item_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        s2_valid <= 1'b1;
      end else if (s2_move) begin
        s2_valid <= 1'b0;
      end
      if (s2_move) begin
        result_valid <= 1'b1;
      end else if (out_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index    <= '0;
      held_pan        <= '0;
      held_left_gain  <= CENTRE_GAIN;
      held_right_gain <= CENTRE_GAIN;
      left_ramp_acc   <= $signed(ACC_W'(CENTRE_GAIN)) <<< MAX_BLOCK_LOG2;
      right_ramp_acc  <= $signed(ACC_W'(CENTRE_GAIN)) <<< MAX_BLOCK_LOG2;
      left_ramp_step  <= '0;
      right_ramp_step <= '0;
    end else if (s1_move) begin
      sample_index   <= last ? '0 : sample_index + IDX_W'(1);
      left_ramp_acc  <= acc_l_used;
      right_ramp_acc <= acc_r_used;
      if (first) begin
        left_ramp_step  <= step_l_new;
        right_ramp_step <= step_r_new;
      end
      if (changed) begin
        held_pan        <= pan_c;
        held_left_gain  <= new_left;
        held_right_gain <= new_right;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_fire) begin
      s1_sample <= sample_in;
      s1_pan    <= pan_amount;
    end
    if (s1_move) begin
      s2_sample <= s1_sample;
      s2_gain_l <= gain_l;
      s2_gain_r <= gain_r;
      s2_end    <= last;
    end
    if (s2_move) begin
      left_out  <= scale_sat(s2_sample, s2_gain_l);
      right_out <= scale_sat(s2_sample, s2_gain_r);
      block_end <= s2_end;
    end
  end

endmodule

`default_nettype wire

### sv/spwf_checker.sv
`default_nettype none

module spwf_checker
  import spwf_pkg::*;
(
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          item_stall,
  input wire logic                          result_valid,
  input wire logic                          result_stall,
  input wire logic signed [SAMPLE_BITS-1:0] left_out,
  input wire logic signed [SAMPLE_BITS-1:0] right_out,
  input wire logic                          block_end
);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result transaction dropped while stalled");

  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      $stable(left_out) && $stable(right_out) && $stable(block_end))
    else $error("stalled result transaction changed");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid && result_stall)
    else $error("item stalled without a stalled result");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid && !item_stall)
    else $error("pipeline not empty after reset");

endmodule

bind stereo_pan_law_with_fade spwf_checker u_spwf_checker (.*);

`default_nettype wire
